// File: hw/rtl/i2cts_pkg.sv
package i2cts_pkg;

  // item operations
  typedef enum logic [2:0] {
    OP_BUS_EVENT = 3'd0,
    OP_START     = 3'd1,
    OP_TICK      = 3'd2,
    OP_BUF_WRITE = 3'd3,
    OP_BUF_READ  = 3'd4
  } op_t;

  // commands to the byte-level bus engine
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_NACK  = 3'd4
  } cmd_t;

  // requests to the slave handler
  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_SIZE_TX = 2'd1,
    REQ_SIZE_RX = 2'd2,
    REQ_DONE    = 2'd3
  } sreq_t;

  // transfer phase
  typedef enum logic [5:0] {
    PH_SUCCESS = 6'b000001,
    PH_ERROR   = 6'b000010,
    PH_START   = 6'b000100,
    PH_WAITSLA = 6'b001000,
    PH_DATA    = 6'b010000,
    PH_LAST    = 6'b100000
  } phase_t;

  // phase codes as reported
  localparam logic [2:0] PHC_SUCCESS = 3'd0;
  localparam logic [2:0] PHC_ERROR   = 3'd1;
  localparam logic [2:0] PHC_START   = 3'd2;
  localparam logic [2:0] PHC_WAITSLA = 3'd3;
  localparam logic [2:0] PHC_DATA    = 3'd4;
  localparam logic [2:0] PHC_LAST    = 3'd5;

  // two-wire status codes
  localparam logic [7:0] ST_START          = 8'h08;
  localparam logic [7:0] ST_REP_START      = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK     = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK    = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK   = 8'h30;
  localparam logic [7:0] ST_MR_SLA_ACK     = 8'h40;
  localparam logic [7:0] ST_MR_DATA_ACK    = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK   = 8'h58;
  localparam logic [7:0] ST_SR_SLA_ACK     = 8'h60;
  localparam logic [7:0] ST_SR_GC_ACK      = 8'h70;
  localparam logic [7:0] ST_SR_DATA_ACK    = 8'h80;
  localparam logic [7:0] ST_SR_DATA_NACK   = 8'h88;
  localparam logic [7:0] ST_SR_GC_DATA_ACK = 8'h90;
  localparam logic [7:0] ST_SR_GC_DATA_NACK = 8'h98;
  localparam logic [7:0] ST_SR_STOP        = 8'hA0;
  localparam logic [7:0] ST_ST_SLA_ACK     = 8'hA8;
  localparam logic [7:0] ST_ST_DATA_ACK    = 8'hB8;
  localparam logic [7:0] ST_ST_DATA_NACK   = 8'hC0;
  localparam logic [7:0] ST_ST_LAST_DATA   = 8'hC8;

  localparam logic [7:0] TIMEOUT_RESET = 8'hFF;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
    logic [6:0] slave_size;
    logic [7:0] target_address;
    logic       read_not_write;
    logic [6:0] transfer_length;
    logic [7:0] elapsed_ms;
    logic [5:0] buffer_index;
    logic [7:0] buffer_value;
  } item_t;

  typedef struct packed {
    cmd_t       bus_command;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] phase;
    logic [7:0] function_code;
    sreq_t      slave_request;
    logic [6:0] done_count;
    logic [6:0] transferred_length;
    logic [7:0] read_data;
  } result_t;

  function automatic logic is_sr_data(input logic [7:0] s);
    return s == ST_SR_DATA_ACK || s == ST_SR_DATA_NACK ||
           s == ST_SR_GC_DATA_ACK || s == ST_SR_GC_DATA_NACK;
  endfunction

  function automatic logic phase_idle(input phase_t p);
    return p == PH_SUCCESS || p == PH_ERROR;
  endfunction

  function automatic logic [2:0] phase_code(input phase_t p);
    logic [2:0] c;
    case (p)
      PH_SUCCESS: c = PHC_SUCCESS;
      PH_ERROR:   c = PHC_ERROR;
      PH_START:   c = PHC_START;
      PH_WAITSLA: c = PHC_WAITSLA;
      PH_DATA:    c = PHC_DATA;
      PH_LAST:    c = PHC_LAST;
      default:    c = PHC_ERROR;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/i2cts_if.sv
interface i2cts_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] status_code;
  logic [7:0] rx_byte;
  logic [6:0] slave_size;
  logic [7:0] target_address;
  logic       read_not_write;
  logic [6:0] transfer_length;
  logic [7:0] elapsed_ms;
  logic [5:0] buffer_index;
  logic [7:0] buffer_value;

  modport source (
    output valid, op, status_code, rx_byte, slave_size, target_address,
           read_not_write, transfer_length, elapsed_ms, buffer_index, buffer_value,
    input  ready
  );
  modport sink (
    input  valid, op, status_code, rx_byte, slave_size, target_address,
           read_not_write, transfer_length, elapsed_ms, buffer_index, buffer_value,
    output ready
  );
endinterface

interface i2cts_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_command;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [2:0] phase;
  logic [7:0] function_code;
  logic [1:0] slave_request;
  logic [6:0] done_count;
  logic [6:0] transferred_length;
  logic [7:0] read_data;

  modport source (
    output valid, bus_command, tx_valid, tx_byte, phase, function_code,
           slave_request, done_count, transferred_length, read_data,
    input  ready
  );
  modport sink (
    input  valid, bus_command, tx_valid, tx_byte, phase, function_code,
           slave_request, done_count, transferred_length, read_data,
    output ready
  );
endinterface

interface i2cts_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/i2c_transfer_sequencer_top.sv
// i2c transfer sequencer: decides the next bus engine command for each item
//
// channels
//   req : one item per handshake (bus status event, master start, ms tick,
//         host buffer write or read), valid/ready
//   rsp : one result item per request item, in order, valid/ready
//   cfg : write of the timeout reload value, always ready; write it only
//         while no item is in flight
// latency: an item accepted at one clock edge is on rsp right after the
//   next edge (input register, decision logic, result register)
// throughput: one item per cycle; the buffer's single read port is fetched
//   as the item enters the input register, so the rate is set by the one
//   registered decision stage
// stall: while rsp is held, one more item is taken into the input register,
//   then req.ready drops until the result register drains
// reset: phase success, indexes, counts, address, function byte and timeout
//   cleared, timeout reload 255; buffer contents are not cleared
module i2c_transfer_sequencer_top
  import i2cts_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  logic         clk,
  input  logic         rst,
  i2cts_req_if.sink    req,
  i2cts_rsp_if.source  rsp,
  i2cts_cfg_if.sink    cfg
);

  localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  // input register
  item_t  in_item;
  item_t  item;
  logic   item_valid;

  // result register
  result_t res_next;
  result_t res;
  logic    res_valid;

  logic               accept;
  logic               consume;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [7:0]         wr_data;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_data;
  logic [CNT_W-1:0]   ahead_index;

  assign in_item.op              = req.op;
  assign in_item.status_code     = req.status_code;
  assign in_item.rx_byte         = req.rx_byte;
  assign in_item.slave_size      = req.slave_size;
  assign in_item.target_address  = req.target_address;
  assign in_item.read_not_write  = req.read_not_write;
  assign in_item.transfer_length = req.transfer_length;
  assign in_item.elapsed_ms      = req.elapsed_ms;
  assign in_item.buffer_index    = req.buffer_index;
  assign in_item.buffer_value    = req.buffer_value;

  // the held item retires when the result register is free or draining
  assign consume   = item_valid && (!res_valid || rsp.ready);
  assign req.ready = !item_valid || consume;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

  // buffer fetch happens as the item is taken: host reads use their own
  // index, everything else the byte index left by the item ahead of it
  assign rd_addr = (req.op == OP_BUF_READ) ? ADDR_W'(req.buffer_index)
                                           : ahead_index[ADDR_W-1:0];

  i2cts_buffer #(
    .DEPTH (BUFFER_BYTES)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  i2cts_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .advance     (consume),
    .mem_rdata   (rd_data),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_data    (cfg.data),
    .res         (res_next),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .ahead_index (ahead_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (consume) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      res <= res_next;
    end
  end

  assign rsp.valid              = res_valid;
  assign rsp.bus_command        = res.bus_command;
  assign rsp.tx_valid           = res.tx_valid;
  assign rsp.tx_byte            = res.tx_byte;
  assign rsp.phase              = res.phase;
  assign rsp.function_code      = res.function_code;
  assign rsp.slave_request      = res.slave_request;
  assign rsp.done_count         = res.done_count;
  assign rsp.transferred_length = res.transferred_length;
  assign rsp.read_data          = res.read_data;

  // a retiring item always leaves a result behind
  a_retire_gives_result: assert property (@(posedge clk) disable iff (rst)
    consume |=> rsp.valid)
    else $error("retired item left no result");

  // a loaded transmit byte always goes with an ack or nack command
  a_tx_with_continue: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.tx_valid |-> rsp.bus_command == CMD_ACK || rsp.bus_command == CMD_NACK)
    else $error("transmit byte without continue command");

  // done count only travels with a receive-done request
  a_done_count_only_on_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.slave_request != REQ_DONE |-> rsp.done_count == 7'd0)
    else $error("done count outside receive done");

  // the buffer is only written while an item retires
  a_write_on_retire: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> consume)
    else $error("buffer write without retiring item");

endmodule

// File: hw/rtl/i2cts_buffer.sv
module i2cts_buffer #(
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [7:0]                              wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [7:0]                              rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first forwarding when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// File: hw/rtl/i2cts_ctrl.sv
module i2cts_ctrl
  import i2cts_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  item_t                                 item,
  input  logic                                  advance,
  input  logic [7:0]                            mem_rdata,
  input  logic                                  cfg_we,
  input  logic [7:0]                            cfg_data,
  output result_t                               res,
  output logic                                  wr_en,
  output logic [((BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1)-1:0] wr_addr,
  output logic [7:0]                            wr_data,
  output logic [$clog2(BUFFER_BYTES + 1)-1:0]   ahead_index
);

  localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CMP_W-1:0] LIMIT     = CMP_W'(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(BUFFER_BYTES);

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  byte_index, byte_index_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [7:0]        address_byte, address_byte_next;
  logic [7:0]        function_byte, function_byte_next;
  logic [7:0]        timeout_left, timeout_left_next;
  logic [7:0]        timeout_reload;

  cmd_t              cmd;
  logic              txv;
  logic [7:0]        txb;
  sreq_t             sreq;
  logic [6:0]        donec;
  logic [7:0]        rd;
  logic              we;
  logic              idx_in, more;
  logic              do_send, do_store, do_aon, do_last_chk;
  logic [CNT_W-1:0]  ssize_clamp, len_clamp;
  logic [CMP_W:0]    done_w;

  assign idx_in = CMP_W'(byte_index) < LIMIT;
  assign more   = byte_index < byte_count;
  assign ssize_clamp = (CMP_W'(item.slave_size) > LIMIT) ? LIMIT_CNT
                                                         : CNT_W'(item.slave_size);
  assign len_clamp   = (CMP_W'(item.transfer_length) > LIMIT) ? LIMIT_CNT
                                                              : CNT_W'(item.transfer_length);
  assign done_w = (CMP_W + 1)'(byte_index) + (CMP_W + 1)'(1);

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    byte_count_next    = byte_count;
    address_byte_next  = address_byte;
    function_byte_next = function_byte;
    timeout_left_next  = timeout_left;
    cmd         = CMD_NONE;
    txv         = 1'b0;
    txb         = 8'h00;
    sreq        = REQ_NONE;
    donec       = 7'd0;
    rd          = 8'h00;
    we          = 1'b0;
    wr_addr     = ADDR_W'(byte_index);
    wr_data     = item.rx_byte;
    do_send     = 1'b0;
    do_store    = 1'b0;
    do_aon      = 1'b0;
    do_last_chk = 1'b0;

    case (item.op)
      OP_BUS_EVENT: begin
        case (phase)
          PH_SUCCESS, PH_ERROR: begin
            if (item.status_code == ST_SR_SLA_ACK || item.status_code == ST_SR_GC_ACK) begin
              byte_count_next   = LIMIT_CNT;
              byte_index_next   = '0;
              timeout_left_next = timeout_reload;
              cmd               = CMD_ACK;
              phase_next        = PH_START;
            end else if (item.status_code == ST_ST_SLA_ACK) begin
              // slave transmit starts at entry zero, prefetched while idle
              sreq            = REQ_SIZE_TX;
              byte_count_next = ssize_clamp;
              txv             = 1'b1;
              txb             = mem_rdata;
              byte_index_next = CNT_W'(1);
              do_aon          = 1'b1;
              phase_next      = PH_DATA;
            end else begin
              timeout_left_next = 8'h00;
              cmd               = CMD_STOP;
            end
          end
          PH_START: begin
            if (item.status_code == ST_START || item.status_code == ST_REP_START) begin
              txv        = 1'b1;
              txb        = address_byte;
              cmd        = CMD_ACK;
              phase_next = PH_WAITSLA;
            end else if (is_sr_data(item.status_code)) begin
              function_byte_next = item.rx_byte;
              sreq               = REQ_SIZE_RX;
              byte_count_next    = ssize_clamp;
              do_aon             = 1'b1;
              phase_next         = PH_DATA;
            end else begin
              phase_next        = PH_ERROR;
              timeout_left_next = 8'h00;
              cmd               = CMD_STOP;
            end
          end
          PH_WAITSLA: begin
            if (item.status_code == ST_MR_SLA_ACK) begin
              cmd        = CMD_ACK;
              phase_next = PH_DATA;
            end else if (item.status_code == ST_MT_SLA_ACK && more) begin
              do_send    = 1'b1;
              cmd        = CMD_ACK;
              phase_next = PH_DATA;
            end else begin
              phase_next        = (item.status_code == ST_MT_SLA_ACK) ? PH_SUCCESS : PH_ERROR;
              timeout_left_next = 8'h00;
              cmd               = CMD_STOP;
            end
          end
          PH_DATA: begin
            if (item.status_code == ST_MR_DATA_ACK) begin
              do_store    = 1'b1;
              do_last_chk = 1'b1;
            end else if (item.status_code == ST_MT_DATA_ACK) begin
              if (more) begin
                do_send = 1'b1;
                cmd     = CMD_ACK;
              end else begin
                phase_next        = PH_SUCCESS;
                timeout_left_next = 8'h00;
                cmd               = CMD_STOP;
              end
            end else if (item.status_code == ST_MT_DATA_NACK) begin
              // target cut the write short
              byte_count_next   = byte_index;
              phase_next        = PH_SUCCESS;
              timeout_left_next = 8'h00;
              cmd               = CMD_STOP;
            end else if (is_sr_data(item.status_code)) begin
              do_store = more;
              do_aon   = 1'b1;
            end else if (item.status_code == ST_SR_STOP) begin
              phase_next        = PH_SUCCESS;
              timeout_left_next = 8'h00;
              cmd               = CMD_ACK;
              sreq              = REQ_DONE;
              donec             = done_w[6:0];
            end else if (item.status_code == ST_ST_DATA_ACK) begin
              if (more) begin
                do_send = 1'b1;
              end else begin
                // pad with zero bytes past the handler's size
                txv = 1'b1;
                txb = 8'h00;
              end
              do_aon = 1'b1;
            end else if (item.status_code == ST_ST_DATA_NACK ||
                         item.status_code == ST_ST_LAST_DATA) begin
              phase_next        = PH_SUCCESS;
              timeout_left_next = 8'h00;
              cmd               = CMD_ACK;
            end else begin
              phase_next        = PH_ERROR;
              timeout_left_next = 8'h00;
              cmd               = CMD_STOP;
            end
          end
          PH_LAST: begin
            phase_next        = (item.status_code == ST_MR_DATA_NACK) ? PH_SUCCESS : PH_ERROR;
            timeout_left_next = 8'h00;
            cmd               = CMD_STOP;
          end
          default: begin
            phase_next        = PH_ERROR;
            timeout_left_next = 8'h00;
            cmd               = CMD_STOP;
          end
        endcase
      end
      OP_START: begin
        if (phase_idle(phase)) begin
          byte_count_next   = len_clamp;
          byte_index_next   = '0;
          address_byte_next = {item.target_address[7:1], item.read_not_write};
          timeout_left_next = timeout_reload;
          phase_next        = PH_START;
          cmd               = CMD_START;
        end
      end
      OP_TICK: begin
        if (timeout_left != 8'h00) begin
          if (item.elapsed_ms > timeout_left) begin
            phase_next = PH_ERROR;
            cmd        = CMD_STOP;
          end else begin
            timeout_left_next = timeout_left - item.elapsed_ms;
          end
        end
      end
      OP_BUF_WRITE: begin
        if (CMP_W'(item.buffer_index) < LIMIT) begin
          we      = 1'b1;
          wr_addr = ADDR_W'(item.buffer_index);
          wr_data = item.buffer_value;
        end
      end
      OP_BUF_READ: begin
        if (CMP_W'(item.buffer_index) < LIMIT) begin
          rd = mem_rdata;
        end
      end
      default: begin
      end
    endcase

    if (do_send) begin
      txv = 1'b1;
      txb = idx_in ? mem_rdata : 8'h00;
      if (idx_in) begin
        byte_index_next = byte_index + CNT_W'(1);
      end
    end
    if (do_store && idx_in) begin
      we              = 1'b1;
      byte_index_next = byte_index + CNT_W'(1);
    end
    if (do_last_chk) begin
      if (byte_index_next < byte_count_next) begin
        cmd = CMD_ACK;
      end else begin
        cmd        = CMD_NACK;
        phase_next = PH_LAST;
      end
    end
    if (do_aon) begin
      cmd = (byte_index_next < byte_count_next) ? CMD_ACK : CMD_NACK;
    end
  end

  assign wr_en = we && advance;

  // entry the next item will send from; idle phases only ever send entry zero
  always_comb begin
    if (advance) begin
      ahead_index = phase_idle(phase_next) ? '0 : byte_index_next;
    end else begin
      ahead_index = phase_idle(phase) ? '0 : byte_index;
    end
  end

  assign res.bus_command        = cmd;
  assign res.tx_valid           = txv;
  assign res.tx_byte            = txb;
  assign res.phase              = phase_code(phase_next);
  assign res.function_code      = function_byte_next;
  assign res.slave_request      = sreq;
  assign res.done_count         = donec;
  assign res.transferred_length = 7'(byte_count_next);
  assign res.read_data          = rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SUCCESS;
      byte_index    <= '0;
      byte_count    <= '0;
      address_byte  <= 8'h00;
      function_byte <= 8'h00;
      timeout_left  <= 8'h00;
    end else if (advance) begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      byte_count    <= byte_count_next;
      address_byte  <= address_byte_next;
      function_byte <= function_byte_next;
      timeout_left  <= timeout_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reload <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_reload <= cfg_data;
    end
  end

endmodule
